/* design/pixel_fingerprint_dissimilarity_assert.svh */
// Assertion macros for the pixel fingerprint dissimilarity block.
// Used by pixel_fingerprint_dissimilarity.sv; expects clk and rst_n in scope.
`ifndef PIXEL_FINGERPRINT_DISSIMILARITY_ASSERT_SVH
`define PIXEL_FINGERPRINT_DISSIMILARITY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/pfd_pkg.sv */
// Shared constants, codes and beat types of the fingerprint dissimilarity block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

  localparam int MAX_FINGERPRINTS = 256;
  localparam int CHANNEL_BITS     = 16;
  localparam int NUM_CH           = 3;
  localparam int FRAC_BITS        = 16;
  localparam int TOL_W            = 17;
  localparam int CFG_IDX_W        = 2;
  localparam int IDX_W  = (MAX_FINGERPRINTS > 1) ? $clog2(MAX_FINGERPRINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_FINGERPRINTS + 1);
  localparam int PROD_W = ((CNT_W + FRAC_BITS) > (CNT_W + TOL_W)) ?
                          (CNT_W + FRAC_BITS) : (CNT_W + TOL_W);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(62259);

  typedef enum logic [1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_APPEND   = 2'd1,
    KIND_CLASSIFY = 2'd2
  } pfd_kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TOL    = CFG_IDX_W'(3);

  typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] pfd_chans_t;

  // One beat travelling down the cell chain.
  typedef struct packed {
    logic             valid;
    logic             classify;  // in-mask classify
    logic             append;    // accepted append, written at cell idx
    logic             dropped;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] n;         // entries after this beat
    logic [CNT_W-1:0] mcnt;      // running mismatch count
    pfd_chans_t       ch;
  } pfd_tok_t;

  // Finished result handed from the judge to the output register.
  typedef struct packed {
    logic             valid;
    logic             marked;
    logic [CNT_W-1:0] mcnt;
    logic [CNT_W-1:0] n;
    logic             dropped;
  } pfd_res_t;

endpackage

`default_nettype wire

/* design/pfd_cell.sv */
// One chain cell: holds one fingerprint, updates the passing beat's mismatch count.
// Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfd_cell
  import pfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [IDX_W-1:0] cell_idx,
  input  pfd_chans_t       lim,
  input  pfd_tok_t         tok_in,
  output pfd_tok_t         tok_out
);

  pfd_chans_t fp_r;
  pfd_tok_t   tok_r;
  pfd_tok_t   tok_nxt;
  logic       miss;
  logic       live;

  always_comb begin
    miss = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (tok_in.ch[c] > fp_r[c]) begin
        if ((tok_in.ch[c] - fp_r[c]) > lim[c]) miss = 1'b1;
      end else begin
        if ((fp_r[c] - tok_in.ch[c]) > lim[c]) miss = 1'b1;
      end
    end
    // entry is live for this beat only if below the beat's entry count
    live    = ({1'b0, cell_idx} < tok_in.n);
    tok_nxt = tok_in;
    if (tok_in.classify && live && miss) tok_nxt.mcnt = tok_in.mcnt + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (adv && tok_in.valid && tok_in.append && (tok_in.idx == cell_idx)) begin
      fp_r <= tok_in.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

/* design/pfd_judge.sv */
// Decision stage: registers entries x tolerance, then compares against mismatches.
// Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfd_judge
  import pfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [TOL_W-1:0] tol,
  input  pfd_tok_t         tok_in,
  output pfd_res_t         res
);

  logic              valid_r;
  logic              cls_r;
  logic              drop_r;
  logic [CNT_W-1:0]  mcnt_r;
  logic [CNT_W-1:0]  n_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] lhs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_r  <= tok_in.classify;
      drop_r <= tok_in.dropped;
      mcnt_r <= tok_in.mcnt;
      n_r    <= tok_in.n;
      prod_r <= PROD_W'(tok_in.n) * PROD_W'(tol);
    end
  end

  // count * 2^16 >= entries * tolerance
  assign lhs = PROD_W'({mcnt_r, {FRAC_BITS{1'b0}}});

  always_comb begin
    res.valid   = valid_r;
    res.marked  = cls_r && (lhs >= prod_r);
    res.mcnt    = mcnt_r;
    res.n       = n_r;
    res.dropped = drop_r;
  end

endmodule

`default_nettype wire

/* design/pixel_fingerprint_dissimilarity.sv */
// Top level of the pixel fingerprint dissimilarity block: entry control, cell chain,
// judge stage and output register. Depends on pfd_pkg, pfd_cell, pfd_judge.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: in_kind selects
//   clear, append or classify; in_chan0..2 are 8.8 channel values; in_mask gates
//   classification. Output channel (out_valid/out_ready) returns exactly one beat
//   per input beat, in order.
//   Config port (cfg_we/cfg_index/cfg_wdata): indexes 0..2 set channel limits,
//   3 sets the Q1.16 tolerance. Write only while the block is idle.
// Timing:
//   Fully pipelined, one beat per cycle sustained unless backpressure stalls the chain.
//   A beat passes one register per chain cell, then the judge register holding the
//   entries x tolerance product, then the output register.
//   Appends and classifies travel the chain in order, so an append lands in its
//   cell before any later pixel reaches that cell.
// Reset:
//   Synchronous, active low. Clears the entry count and all beat valid bits and
//   restores the config registers. Fingerprint storage is not cleared; cells at or
//   above the entry count are ignored.
// Backpressure:
//   The chain only stalls when a finished result sits in the judge stage while the
//   output register holds an untaken beat; bubbles keep flowing otherwise.
`timescale 1ns / 1ps
`default_nettype none

module pixel_fingerprint_dissimilarity
  import pfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // config write port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [TOL_W-1:0]        cfg_wdata,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_kind,
  input  logic [CHANNEL_BITS-1:0] in_chan0,
  input  logic [CHANNEL_BITS-1:0] in_chan1,
  input  logic [CHANNEL_BITS-1:0] in_chan2,
  input  logic                    in_mask,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_marked,
  output logic [CNT_W-1:0]        out_mismatch_count,
  output logic [CNT_W-1:0]        out_entry_count,
  output logic                    out_dropped
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_FINGERPRINTS);

  // config registers
  pfd_chans_t       lim_r;
  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= '0;
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMIT0: lim_r[0] <= cfg_wdata[CHANNEL_BITS-1:0];
        REG_LIMIT1: lim_r[1] <= cfg_wdata[CHANNEL_BITS-1:0];
        REG_LIMIT2: lim_r[2] <= cfg_wdata[CHANNEL_BITS-1:0];
        REG_TOL:    tol_r    <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // pipeline advance: stall only when judge and output register are both full
  pfd_res_t res;
  logic     out_valid_r;
  logic     adv;
  logic     load;

  assign adv      = !res.valid || !out_valid_r || out_ready;
  assign in_ready = adv;
  assign load     = adv && res.valid;

  // entry count and head beat
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  pfd_tok_t         head;
  logic             accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    cnt_nxt       = cnt_r;
    head.valid    = in_valid;
    head.classify = 1'b0;
    head.append   = 1'b0;
    head.dropped  = 1'b0;
    head.idx      = cnt_r[IDX_W-1:0];
    head.mcnt     = '0;
    head.ch[0]    = in_chan0;
    head.ch[1]    = in_chan1;
    head.ch[2]    = in_chan2;
    case (in_kind)
      KIND_CLEAR: begin
        cnt_nxt = '0;
      end
      KIND_APPEND: begin
        if (cnt_r == CNT_FULL) begin
          head.dropped = 1'b1;
        end else begin
          head.append = 1'b1;
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
      end
      KIND_CLASSIFY: begin
        head.classify = in_mask;
      end
      default: ;  // unused kind: passes through with the count only
    endcase
    head.n = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  // cell chain, one fingerprint per cell
  pfd_tok_t chain [0:MAX_FINGERPRINTS];

  assign chain[0] = head;

  for (genvar g = 0; g < MAX_FINGERPRINTS; g++) begin : g_cell
    pfd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (IDX_W'(g)),
      .lim      (lim_r),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
  end

  pfd_judge u_judge (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .tol    (tol_r),
    .tok_in (chain[MAX_FINGERPRINTS]),
    .res    (res)
  );

  // output register
  logic             marked_r;
  logic [CNT_W-1:0] mcnt_r;
  logic [CNT_W-1:0] ecnt_r;
  logic             drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      marked_r <= res.marked;
      mcnt_r   <= res.mcnt;
      ecnt_r   <= res.n;
      drop_r   <= res.dropped;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_marked         = marked_r;
  assign out_mismatch_count = mcnt_r;
  assign out_entry_count    = ecnt_r;
  assign out_dropped        = drop_r;

  `include "pixel_fingerprint_dissimilarity_assert.svh"

  `PFD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_FULL, "entry count above table size")
  `PFD_ASSERT_NEXT(a_full_hold, accept && (in_kind == KIND_APPEND) && (cnt_r == CNT_FULL), $stable(cnt_r), "append to full table changed the count")
  `PFD_ASSERT_NOW(a_drop_full, out_valid && out_dropped, (out_entry_count == CNT_FULL) && !out_marked && (out_mismatch_count == '0), "dropped beat with wrong fields")
  `PFD_ASSERT_NOW(a_mcnt_le_n, out_valid, out_mismatch_count <= out_entry_count, "mismatch count above entry count")

endmodule

`default_nettype wire

/* tb/dissim_checker.sv */
// Checker for the fingerprint dissimilarity block: watches config, input and result beats,
// predicts each verdict and compares it field by field. Depends on pfd_pkg.
`timescale 1ns / 1ps

module dissim_checker
  import pfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [TOL_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              in_kind,
  input  logic [CHANNEL_BITS-1:0] in_chan0,
  input  logic [CHANNEL_BITS-1:0] in_chan1,
  input  logic [CHANNEL_BITS-1:0] in_chan2,
  input  logic                    in_mask,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    out_marked,
  input  logic [CNT_W-1:0]        out_mismatch_count,
  input  logic [CNT_W-1:0]        out_entry_count,
  input  logic                    out_dropped,
  output int                      fail_count,
  output int                      outstanding
);

  typedef struct packed {
    logic             marked;
    logic [CNT_W-1:0] mcount;
    logic [CNT_W-1:0] entries;
    logic             dropped;
  } verdict_t;

  // predictor copy of the table and registers
  logic [CHANNEL_BITS-1:0] fp_store [MAX_FINGERPRINTS][NUM_CH];
  int                      held;
  logic [CHANNEL_BITS-1:0] limit_q [NUM_CH];
  logic [TOL_W-1:0]        tol_q;

  verdict_t verdict_q[$];
  int       beat_no;

  function automatic verdict_t next_verdict(logic [1:0] kind, logic [CHANNEL_BITS-1:0] c0,
                                            logic [CHANNEL_BITS-1:0] c1,
                                            logic [CHANNEL_BITS-1:0] c2, logic mask);
    verdict_t                v;
    logic [CHANNEL_BITS-1:0] px [NUM_CH];
    int                      miss_n;
    int                      d;
    bit                      miss;
    v = '0;
    px[0] = c0;
    px[1] = c1;
    px[2] = c2;
    case (kind)
      KIND_CLEAR: held = 0;
      KIND_APPEND: begin
        if (held < MAX_FINGERPRINTS) begin
          for (int c = 0; c < NUM_CH; c++) fp_store[held][c] = px[c];
          held++;
        end else begin
          v.dropped = 1'b1;
        end
      end
      KIND_CLASSIFY: begin
        if (mask) begin
          miss_n = 0;
          for (int k = 0; k < held; k++) begin
            miss = 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
              d = int'(fp_store[k][c]) - int'(px[c]);
              if (d < 0) d = -d;
              if (d > int'(limit_q[c])) miss = 1'b1;
            end
            if (miss) miss_n++;
          end
          v.mcount = CNT_W'(miss_n);
          v.marked = (longint'(miss_n) * 64'd65536 >= longint'(held) * longint'(tol_q));
        end
      end
      default: ;  // unused kind: nothing changes
    endcase
    v.entries = CNT_W'(held);
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      held       = 0;
      limit_q[0] = '0;
      limit_q[1] = '0;
      limit_q[2] = '0;
      tol_q      = TOL_RESET;
      verdict_q.delete();
      fail_count = 0;
      beat_no    = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_marked, out_mismatch_count, out_entry_count, out_dropped};
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result beat %0d arrived with nothing pending", beat_no);
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result beat %0d: expected marked=%0d mcount=%0d entries=%0d ",
                        "dropped=%0d, got marked=%0d mcount=%0d entries=%0d dropped=%0d"},
                       beat_no, want.marked, want.mcount, want.entries, want.dropped,
                       got.marked, got.mcount, got.entries, got.dropped);
          end
        end
        beat_no++;
      end
      if (in_valid && in_ready)
        verdict_q.insert(verdict_q.size(),
                         next_verdict(in_kind, in_chan0, in_chan1, in_chan2, in_mask));
      if (cfg_we) begin
        case (cfg_index)
          REG_LIMIT0: limit_q[0] = cfg_wdata[CHANNEL_BITS-1:0];
          REG_LIMIT1: limit_q[1] = cfg_wdata[CHANNEL_BITS-1:0];
          REG_LIMIT2: limit_q[2] = cfg_wdata[CHANNEL_BITS-1:0];
          REG_TOL:    tol_q      = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding <= verdict_q.size();
  end

endmodule

/* tb/tb.sv */
// Top of the fingerprint dissimilarity testbench: clock, reset, config writes, stimulus,
// receiver stalls and the verdict. Depends on pfd_pkg, the block and dissim_checker.
`timescale 1ns / 1ps

module tb;
  import pfd_pkg::*;

  // kind value the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // cycles with no accepted beat before giving up
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = MAX_FINGERPRINTS + 40;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] c0;
    logic [CHANNEL_BITS-1:0] c1;
    logic [CHANNEL_BITS-1:0] c2;
  } colour_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [TOL_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_kind = '0;
  logic [CHANNEL_BITS-1:0] in_chan0 = '0;
  logic [CHANNEL_BITS-1:0] in_chan1 = '0;
  logic [CHANNEL_BITS-1:0] in_chan2 = '0;
  logic                    in_mask = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_marked;
  logic [CNT_W-1:0]        out_mismatch_count;
  logic [CNT_W-1:0]        out_entry_count;
  logic                    out_dropped;

  int fail_count;
  int outstanding;
  int quiet = 0;

  // idle percentages: sender gaps and receiver stalls
  int snd_idle  = 0;
  int rcv_stall = 0;

  // limits now programmed, used to aim pixels at the thresholds
  logic [CHANNEL_BITS-1:0] lim_now [NUM_CH] = '{default: '0};
  // rough copy of what the table holds, only for picking nearby pixels
  colour_t stock_fp[$];

  pixel_fingerprint_dissimilarity DUT (.*);
  dissim_checker CHK (.*);

  always #4 clk = ~clk;

  // receiver: random stalls at the current rate
  always @(posedge clk) out_ready <= ($urandom_range(99) >= rcv_stall);

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic colour_t rand_colour();
    colour_t px;
    px.c0 = CHANNEL_BITS'($urandom());
    px.c1 = CHANNEL_BITS'($urandom());
    px.c2 = CHANNEL_BITS'($urandom());
    return px;
  endfunction

  // value close to b: exactly at the limit, one past it, or somewhere inside a window
  function automatic logic [CHANNEL_BITS-1:0] near_chan(logic [CHANNEL_BITS-1:0] b,
                                                        logic [CHANNEL_BITS-1:0] lim);
    int off;
    int v;
    case ($urandom_range(3))
      0:       off = int'(lim);
      1:       off = int'(lim) + 1;
      default: off = $urandom_range(int'(lim) + 3);
    endcase
    v = $urandom_range(1) ? int'(b) + off : int'(b) - off;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return CHANNEL_BITS'(v);
  endfunction

  function automatic colour_t near_colour(colour_t base);
    colour_t px;
    px.c0 = near_chan(base.c0, lim_now[0]);
    px.c1 = near_chan(base.c1, lim_now[1]);
    px.c2 = near_chan(base.c2, lim_now[2]);
    return px;
  endfunction

  function automatic colour_t cluster_colour(colour_t centre, logic [CHANNEL_BITS-1:0] spread);
    colour_t px;
    px.c0 = near_chan(centre.c0, spread);
    px.c1 = near_chan(centre.c1, spread);
    px.c2 = near_chan(centre.c2, spread);
    return px;
  endfunction

  // one input beat; valid holds until accepted
  task automatic send_item(logic [1:0] kind, colour_t px, logic mask);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_chan0 <= px.c0;
    in_chan1 <= px.c1;
    in_chan2 <= px.c2;
    in_mask  <= mask;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KIND_CLEAR) stock_fp.delete();
    else if (kind == KIND_APPEND && stock_fp.size() < MAX_FINGERPRINTS)
      stock_fp.insert(stock_fp.size(), px);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // four back-to-back writes, one per register; block must be idle
  task automatic set_config(logic [TOL_W-1:0] l0, logic [TOL_W-1:0] l1,
                            logic [TOL_W-1:0] l2, logic [TOL_W-1:0] tol);
    logic [TOL_W-1:0]     vals [4];
    logic [CFG_IDX_W-1:0] idx  [4];
    vals = '{l0, l1, l2, tol};
    idx  = '{REG_LIMIT0, REG_LIMIT1, REG_LIMIT2, REG_TOL};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    lim_now[0] = l0[CHANNEL_BITS-1:0];
    lim_now[1] = l1[CHANNEL_BITS-1:0];
    lim_now[2] = l2[CHANNEL_BITS-1:0];
  endtask

  // mostly append bursts from one colour cluster followed by pixels aimed at the
  // stored fingerprints; the rest are clears, ignored kinds and random pixels
  task automatic run_mix(int n);
    int                      sent;
    int                      pick;
    colour_t                 centre;
    colour_t                 px;
    logic [CHANNEL_BITS-1:0] spread;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(KIND_CLEAR, rand_colour(), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 14) begin
        send_item(KIND_UNUSED, rand_colour(), 1'($urandom_range(1)));
        sent++;
      end else begin
        centre = rand_colour();
        spread = CHANNEL_BITS'(1 << $urandom_range(15));
        repeat ($urandom_range(8)) begin
          send_item(KIND_APPEND, cluster_colour(centre, spread), 1'($urandom_range(1)));
          sent++;
        end
        repeat ($urandom_range(1, 10)) begin
          if (stock_fp.size() > 0 && $urandom_range(99) < 80)
            px = near_colour(stock_fp[$urandom_range(stock_fp.size() - 1)]);
          else
            px = rand_colour();
          send_item(KIND_CLASSIFY, px, $urandom_range(99) < 85);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int      snd_mode [4];
    int      rcv_mode [4];
    colour_t centre;
    snd_mode = '{0, 64, 0, 14};
    rcv_mode = '{0, 0, 64, 14};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset register values: limits zero, tolerance 0.95
    send_item(KIND_CLASSIFY, '{16'h0000, 16'h0000, 16'h0000}, 1'b1);  // empty table marks
    send_item(KIND_CLASSIFY, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);  // outside mask
    send_item(KIND_UNUSED,   '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
    send_item(KIND_APPEND,   '{16'h0000, 16'h0000, 16'h0000}, 1'b0);
    send_item(KIND_APPEND,   '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
    send_item(KIND_APPEND,   '{16'h8000, 16'h00FF, 16'hFF00}, 1'b0);
    send_item(KIND_CLASSIFY, '{16'h0000, 16'h0000, 16'h0000}, 1'b1);
    send_item(KIND_CLASSIFY, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
    send_item(KIND_CLASSIFY, '{16'h8000, 16'h00FF, 16'hFF00}, 1'b1);
    send_item(KIND_CLASSIFY, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_item(KIND_UNUSED,   '{16'h0000, 16'h0000, 16'h0000}, 1'b0);
    send_item(KIND_APPEND,   '{16'h0001, 16'h0001, 16'h0001}, 1'b1);
    send_item(KIND_CLASSIFY, '{16'h0001, 16'h0001, 16'h0001}, 1'b1);
    send_item(KIND_CLEAR,    '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
    send_item(KIND_CLASSIFY, '{16'h1234, 16'h5678, 16'h9ABC}, 1'b1);  // cleared table marks
    send_item(KIND_UNUSED,   '{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b1);
    send_item(KIND_CLEAR,    '{16'h0000, 16'h0000, 16'h0000}, 1'b0);  // clear when empty
    send_item(KIND_APPEND,   '{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b1);
    send_item(KIND_CLASSIFY, '{16'h5555, 16'hAAAA, 16'h5555}, 1'b1);
    send_item(KIND_CLASSIFY, '{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b1);  // exact match

    // random phases; each one drains, reprograms and picks an idling mode
    for (int p = 0; p < 8; p++) begin
      wait_drain();
      case (p)
        0: set_config('0, '0, '0, '0);
        1: set_config(17'h1FFFF, 17'h1FFFF, 17'h0FFFF, 17'h1FFFF);  // tolerance above one
        2: set_config(17'($urandom_range(1023)), 17'($urandom_range(1023)),
                      17'($urandom_range(1023)), 17'd65536);
        3: set_config(17'($urandom_range(65535)), 17'($urandom_range(65535)),
                      17'($urandom_range(65535)), TOL_RESET);
        default: set_config(17'($urandom_range(17'h1FFFF)), 17'($urandom_range(17'h1FFFF)),
                            17'($urandom_range(4095)), 17'($urandom_range(17'h1FFFF)));
      endcase
      snd_idle  = snd_mode[p % 4];
      rcv_stall = rcv_mode[p % 4];
      if (p == 6) begin
        // fill the table past its end: the last appends are dropped
        centre = rand_colour();
        send_item(KIND_CLEAR, rand_colour(), 1'b0);
        repeat (MAX_FINGERPRINTS + 3)
          send_item(KIND_APPEND, cluster_colour(centre, 16'h0400), 1'($urandom_range(1)));
        repeat (20)
          send_item(KIND_CLASSIFY, near_colour(stock_fp[$urandom_range(MAX_FINGERPRINTS - 1)]),
                    $urandom_range(99) < 90);
        send_item(KIND_APPEND, rand_colour(), 1'b1);
      end
      run_mix(80);
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/pfd_pkg.sv
design/pfd_cell.sv
design/pfd_judge.sv
design/pixel_fingerprint_dissimilarity.sv
tb/dissim_checker.sv
tb/tb.sv
